FILE: hw/rtl/dsfp_pkg.sv
`default_nettype none

package dsfp_pkg;

  localparam logic [7:0] HDR0      = 8'h5A;
  localparam logic [7:0] HDR1      = 8'hA5;
  localparam logic [7:0] CMD_READ  = 8'h81;
  localparam logic [7:0] ADDR_DATE = 8'h20;
  localparam logic [7:0] LEN_EXTRA = 8'd2;
  localparam logic [4:0] ABANDON_AFTER = 5'd14;

  localparam logic [1:0] MARK_NONE    = 2'd0;
  localparam logic [1:0] MARK_READ    = 2'd1;
  localparam logic [1:0] MARK_PENDING = 2'd2;
  localparam logic [1:0] MARK_DONE    = 2'd3;

  localparam logic KIND_MESSAGE = 1'b0;
  localparam logic KIND_DATE    = 1'b1;

  localparam logic FUNC_BYTE       = 1'b0;
  localparam logic FUNC_CLEAR_DATE = 1'b1;

  typedef struct packed {
    logic       valid;
    logic       event_kind;
    logic [7:0] picture_id;
    logic [7:0] message_code;
    logic [7:0] date_year;
    logic [7:0] date_month;
    logic [7:0] date_day;
  } res_t;

  // high*10 + low, nibbles taken as they are
  function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, b[7:4]};
    lo = {4'd0, b[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dsfp_if.sv
`default_nettype none

interface dsfp_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, func, rx_byte, input ready);
  modport sink   (input valid, func, rx_byte, output ready);
endinterface

interface dsfp_out_if;
  logic       valid;
  logic       ready;
  logic       event_kind;
  logic [7:0] picture_id;
  logic [7:0] message_code;
  logic [7:0] date_year;
  logic [7:0] date_month;
  logic [7:0] date_day;

  modport source (output valid, event_kind, picture_id, message_code,
                  date_year, date_month, date_day, input ready);
  modport sink   (input valid, event_kind, picture_id, message_code,
                  date_year, date_month, date_day, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dsfp_parser.sv
`default_nettype none

module dsfp_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          step,
  input  wire logic          func,
  input  wire logic [7:0]    rx_byte,
  output dsfp_pkg::res_t     res
);
  import dsfp_pkg::*;

  localparam logic [4:0] POS_HDR0  = 5'd0;
  localparam logic [4:0] POS_HDR1  = 5'd1;
  localparam logic [4:0] POS_LEN   = 5'd2;
  localparam logic [4:0] POS_CMD   = 5'd3;
  localparam logic [4:0] POS_ADDR  = 5'd4;
  localparam logic [4:0] POS_FILL  = 5'd5;
  localparam logic [4:0] POS_YEAR  = 5'd6;
  localparam logic [4:0] POS_MONTH = 5'd7;
  localparam logic [4:0] POS_DAY   = 5'd8;

  logic [4:0] pos_r, pos_nxt;
  logic [7:0] len_r, len_nxt;
  logic [1:0] mark_r, mark_nxt;
  logic [7:0] pic_r, pic_nxt;
  logic [7:0] year_r, year_nxt;
  logic [7:0] month_r, month_nxt;
  logic [7:0] day_r, day_nxt;
  logic [4:0] pos_inc;
  logic [7:0] pos_inc_w;
  logic [7:0] pos_w;

  assign pos_inc   = pos_r + 5'd1;
  assign pos_w     = {3'd0, pos_r};
  assign pos_inc_w = pos_w + 8'd1;

  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    mark_nxt  = mark_r;
    pic_nxt   = pic_r;
    year_nxt  = year_r;
    month_nxt = month_r;
    day_nxt   = day_r;
    res       = '0;

    if (func == FUNC_CLEAR_DATE) begin
      mark_nxt  = MARK_NONE;
      year_nxt  = '0;
      month_nxt = '0;
      day_nxt   = '0;
    end else begin
      unique case (pos_r)
        POS_HDR0: pos_nxt = (rx_byte == HDR0) ? POS_HDR1 : POS_HDR0;
        POS_HDR1: pos_nxt = (rx_byte == HDR1) ? POS_LEN : POS_HDR0;
        POS_LEN: begin
          len_nxt = rx_byte + LEN_EXTRA;
          pos_nxt = POS_CMD;
        end
        POS_CMD: begin
          pos_nxt = POS_ADDR;
          if (rx_byte == CMD_READ) mark_nxt = MARK_READ;
        end
        POS_ADDR: begin
          pos_nxt = POS_FILL;
          if (rx_byte == ADDR_DATE) mark_nxt = MARK_PENDING;
        end
        POS_FILL: pos_nxt = POS_YEAR;
        default: begin
          if (mark_r == MARK_PENDING) begin
            priority if (pos_r == POS_YEAR) begin
              year_nxt = bcd_to_bin(rx_byte);
              pos_nxt  = POS_MONTH;
            end else if (pos_r == POS_MONTH) begin
              month_nxt = bcd_to_bin(rx_byte);
              pos_nxt   = POS_DAY;
            end else if (pos_r == POS_DAY) begin
              day_nxt          = bcd_to_bin(rx_byte);
              mark_nxt         = MARK_DONE;
              pos_nxt          = POS_HDR0;
              res.valid        = 1'b1;
              res.event_kind   = KIND_DATE;
              res.date_year    = year_r;
              res.date_month   = month_r;
              res.date_day     = day_nxt;
            end else begin
              pos_nxt = POS_HDR0;
            end
          end else begin
            priority if (pos_inc_w == len_r) begin
              pic_nxt = rx_byte;
              pos_nxt = pos_inc;
            end else if (pos_w == len_r) begin
              pos_nxt          = POS_HDR0;
              res.valid        = 1'b1;
              res.event_kind   = KIND_MESSAGE;
              res.picture_id   = pic_r;
              res.message_code = rx_byte;
            end else if (pos_r > ABANDON_AFTER) begin
              pos_nxt = POS_HDR0;
            end else begin
              pos_nxt = pos_inc;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      len_r   <= '0;
      mark_r  <= MARK_NONE;
      pic_r   <= '0;
      year_r  <= '0;
      month_r <= '0;
      day_r   <= '0;
    end else if (step) begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      mark_r  <= mark_nxt;
      pic_r   <= pic_nxt;
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= day_nxt;
    end
  end

  // count never runs past two beyond the abandon limit
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= ABANDON_AFTER + 5'd2)
    else $error("byte position out of range");

  a_date_done: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid && res.event_kind == KIND_DATE |=> mark_r == MARK_DONE)
    else $error("date event without done mark");

  a_msg_pos: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid && res.event_kind == KIND_MESSAGE |-> pos_w == len_r && pos_r > POS_FILL)
    else $error("message event at wrong count");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step && func == FUNC_CLEAR_DATE |=> mark_r == MARK_NONE && year_r == 8'd0
      && $stable(pos_r))
    else $error("clear date left state behind");

endmodule

`default_nettype wire

FILE: hw/rtl/display_serial_frame_parser_core.sv
`default_nettype none
// Display serial frame parser.
// in_ch carries one beat per received UART byte (func = 0) or a clear-date
// request (func = 1). out_ch carries completed events: a message event
// (held picture id and message code) or a date event (decoded year, month,
// day). Both channels use valid/ready; a beat moves when both are high.
// An accepted beat sits in the input register and is parsed from there;
// its event, if any, is loaded into the output register when the beat
// steps, and out_ch.valid is driven from that output register.
// Throughput is one beat per cycle while the input register is not held;
// the parse is a single pass of small logic between the input and output registers.
// Most beats produce no event; those advance even while an event waits.
// When an event waits with out_ch.ready low and the pending beat would
// produce an event, the input register holds and in_ch.ready drops.
// Reset (rst_n low, synchronous) empties both registers, returns the frame
// count to the header search and clears the date mark, picture id and date.
module display_serial_frame_parser_core (
  input wire logic  clk,
  input wire logic  rst_n,
  dsfp_in_if.sink   in_ch,
  dsfp_out_if.source out_ch
);
  import dsfp_pkg::*;

  logic       in_valid_r;
  logic       in_func_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  res_t       out_r;
  res_t       res;
  logic       out_free;
  logic       step;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign step        = in_valid_r && (out_free || !res.valid);
  assign in_ch.ready = !in_valid_r || step;

  dsfp_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .func    (in_func_r),
    .rx_byte (in_byte_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_func_r <= in_ch.func;
      in_byte_r <= in_ch.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res.valid) begin
      out_r <= res;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_r.event_kind;
  assign out_ch.picture_id   = out_r.picture_id;
  assign out_ch.message_code = out_r.message_code;
  assign out_ch.date_year    = out_r.date_year;
  assign out_ch.date_month   = out_r.date_month;
  assign out_ch.date_day     = out_r.date_day;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !(step && res.valid))
    else $error("pending event overwritten");

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !step |=> in_valid_r && $stable(in_byte_r) && $stable(in_func_r))
    else $error("stalled beat lost");

  a_event_load: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.valid |=> out_valid_r)
    else $error("event not registered");

endmodule

`default_nettype wire
